@@ sv/chc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chc_pkg
// Shared types and constants of the cartridge header checker: payload
// structs, header addresses and the boot logo table.
// ----------------------------------------------------------------------------
package chc_pkg;

    // Header addresses.
    localparam logic [8:0] ADDR_LOGO_START = 9'h104;
    localparam logic [8:0] ADDR_SUM_START  = 9'h134;
    localparam logic [8:0] ADDR_TYPE       = 9'h147;
    localparam logic [8:0] ADDR_ROM_SIZE   = 9'h148;
    localparam logic [8:0] ADDR_RAM_SIZE   = 9'h149;
    localparam logic [8:0] ADDR_VERSION    = 9'h14C;
    localparam logic [8:0] ADDR_CHECK      = 9'h14D;

    localparam int LOGO_LEN = 48;
    localparam int LOGO_IDX_W = $clog2(LOGO_LEN);

    // Mapper class codes.
    localparam logic [2:0] MAPPER_UNKNOWN = 3'd0;
    localparam logic [2:0] MAPPER_NROM    = 3'd1;
    localparam logic [2:0] MAPPER_MBC1    = 3'd2;
    localparam logic [2:0] MAPPER_MBC2    = 3'd3;
    localparam logic [2:0] MAPPER_MMM01   = 3'd4;
    localparam logic [2:0] MAPPER_MBC3    = 3'd5;
    localparam logic [2:0] MAPPER_MBC4    = 3'd6;
    localparam logic [2:0] MAPPER_MBC5    = 3'd7;

    // Boot logo bytes at 0x104 through 0x133.
    localparam logic [7:0] LOGO_TABLE [0:LOGO_LEN-1] = '{
        8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B,
        8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0C, 8'h00, 8'h0D,
        8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
        8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99,
        8'hBB, 8'hBB, 8'h67, 8'h63, 8'h6E, 8'h0E, 8'hEC, 8'hCC,
        8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E
    };

    typedef struct packed {
        logic [8:0] header_offset;
        logic [7:0] header_byte;
    } chc_in_t;

    typedef struct packed {
        logic       header_valid;
        logic       logo_ok;
        logic       checksum_ok;
        logic [7:0] computed_checksum;
        logic [7:0] stored_checksum;
        logic [9:0] rom_banks;
        logic [4:0] ram_banks;
        logic [2:0] mapper_class;
        logic       has_battery;
        logic [7:0] cart_type_out;
        logic [7:0] version_out;
    } chc_out_t;

    // Decoded cartridge properties passed from the decoder to the top level.
    typedef struct packed {
        logic [9:0] rom_banks;
        logic [4:0] ram_banks;
        logic [2:0] mapper_class;
        logic       has_battery;
    } chc_decoded_t;

endpackage

@@ sv/chc_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chc_decode
// Decodes the latched cartridge type and size codes into bank counts,
// mapper class and battery flag.
// ----------------------------------------------------------------------------
module chc_decode import chc_pkg::*; (
    input  logic [7:0]   cart_type,
    input  logic [7:0]   rom_size_code,
    input  logic [7:0]   ram_size_code,
    output chc_decoded_t decoded
);

    // All decoded fields come from one block so the output struct has a
    // single driver.
    always_comb begin
        // ROM banks: powers of two for small codes, three odd sizes, else two.
        if (rom_size_code <= 8'd8) begin
            decoded.rom_banks = 10'd2 << rom_size_code[3:0];
        end else begin
            unique case (rom_size_code)
                8'h52:   decoded.rom_banks = 10'd72;
                8'h53:   decoded.rom_banks = 10'd80;
                8'h54:   decoded.rom_banks = 10'd96;
                default: decoded.rom_banks = 10'd2;
            endcase
        end

        // RAM banks.
        unique case (ram_size_code)
            8'h01, 8'h02: decoded.ram_banks = 5'd1;
            8'h03:        decoded.ram_banks = 5'd4;
            8'h04:        decoded.ram_banks = 5'd16;
            8'h05:        decoded.ram_banks = 5'd8;
            default:      decoded.ram_banks = 5'd0;
        endcase

        // Mapper class, numbered densely with zero for unrecognized types.
        unique case (cart_type)
            8'h00, 8'h08, 8'h09:                    decoded.mapper_class = MAPPER_NROM;
            8'h01, 8'h02, 8'h03:                    decoded.mapper_class = MAPPER_MBC1;
            8'h05, 8'h06:                           decoded.mapper_class = MAPPER_MBC2;
            8'h0B, 8'h0C, 8'h0D:                    decoded.mapper_class = MAPPER_MMM01;
            8'h0F, 8'h10, 8'h11, 8'h12, 8'h13:      decoded.mapper_class = MAPPER_MBC3;
            8'h15, 8'h16, 8'h17:                    decoded.mapper_class = MAPPER_MBC4;
            8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E:
                                                    decoded.mapper_class = MAPPER_MBC5;
            default:                                decoded.mapper_class = MAPPER_UNKNOWN;
        endcase

        // Battery-backed cartridge types.
        unique case (cart_type)
            8'h03, 8'h06, 8'h09, 8'h0D, 8'h0F, 8'h10,
            8'h13, 8'h17, 8'h1B, 8'h1E, 8'h22, 8'hFF: decoded.has_battery = 1'b1;
            default:                                  decoded.has_battery = 1'b0;
        endcase
    end

endmodule

@@ sv/cartridge_header_checker.sv @@
`timescale 1ns / 1ps
// An accepted 0x14D byte's result goes to the output register, or to the skid
// register while m_ready stalls it. Throughput: one header byte per cycle while
// the skid is empty, so input continues while one result waits for m_ready.
// Reset: synchronous active-low aresetn clears the checksum, logo flag,
// latched header fields and both output valid flags.
// ----------------------------------------------------------------------------
// cartridge_header_checker
// Checks a cartridge header streamed one byte per transfer: logo compare,
// header checksum, and decode of type, ROM size and RAM size.
// ----------------------------------------------------------------------------
module cartridge_header_checker import chc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  chc_in_t  s_item,
    output logic     m_valid,
    input  logic     m_ready,
    output chc_out_t m_result
);

    logic       logo_mismatch_reg, logo_mismatch_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic [7:0] cart_type_reg, cart_type_next;
    logic [7:0] rom_size_code_reg, rom_size_code_next;
    logic [7:0] ram_size_code_reg, ram_size_code_next;
    logic [7:0] version_byte_reg, version_byte_next;

    logic     out_valid_reg, out_valid_next;
    chc_out_t out_data_reg, out_data_next;
    logic     skid_valid_reg, skid_valid_next;
    chc_out_t skid_data_reg, skid_data_next;

    logic                  accept;
    logic                  in_range;
    logic                  is_logo;
    logic                  is_sum;
    logic                  is_check;
    logic [8:0]            logo_offset;
    logic [LOGO_IDX_W-1:0] logo_idx;
    logic                  logo_ok;
    logic                  checksum_ok;
    logic                  result_load;
    chc_decoded_t          decoded;
    chc_out_t              result;

    assign accept = s_valid && s_ready;
    assign s_ready = !skid_valid_reg;

    // Address classification.
    assign in_range    = (s_item.header_offset >= ADDR_LOGO_START) &&
                         (s_item.header_offset <= ADDR_CHECK);
    assign is_logo     = in_range && (s_item.header_offset < ADDR_SUM_START);
    assign is_sum      = in_range && !is_logo && (s_item.header_offset < ADDR_CHECK);
    assign is_check    = s_item.header_offset == ADDR_CHECK;
    assign logo_offset = s_item.header_offset - ADDR_LOGO_START;
    assign logo_idx    = logo_offset[LOGO_IDX_W-1:0];

    // Header state update for one accepted byte.
    always_comb begin
        logo_mismatch_next = logo_mismatch_reg;
        running_sum_next   = running_sum_reg;
        cart_type_next     = cart_type_reg;
        rom_size_code_next = rom_size_code_reg;
        ram_size_code_next = ram_size_code_reg;
        version_byte_next  = version_byte_reg;
        if (accept && is_logo) begin
            if (s_item.header_offset == ADDR_LOGO_START) begin
                logo_mismatch_next = 1'b0;
                running_sum_next   = 8'd0;
            end
            if (s_item.header_byte != LOGO_TABLE[logo_idx]) begin
                logo_mismatch_next = 1'b1;
            end
        end
        if (accept && is_sum) begin
            running_sum_next = running_sum_reg - s_item.header_byte - 8'd1;
            if (s_item.header_offset == ADDR_TYPE) begin
                cart_type_next = s_item.header_byte;
            end
            if (s_item.header_offset == ADDR_ROM_SIZE) begin
                rom_size_code_next = s_item.header_byte;
            end
            if (s_item.header_offset == ADDR_RAM_SIZE) begin
                ram_size_code_next = s_item.header_byte;
            end
            if (s_item.header_offset == ADDR_VERSION) begin
                version_byte_next = s_item.header_byte;
            end
        end
    end

    chc_decode u_decode (
        .cart_type     (cart_type_reg),
        .rom_size_code (rom_size_code_reg),
        .ram_size_code (ram_size_code_reg),
        .decoded       (decoded)
    );

    // Result assembled from the state left by the bytes before 0x14D and the 0x14D byte.
    assign logo_ok     = !logo_mismatch_reg;
    assign checksum_ok = s_item.header_byte == running_sum_reg;

    always_comb begin
        result.header_valid      = logo_ok && checksum_ok;
        result.logo_ok           = logo_ok;
        result.checksum_ok       = checksum_ok;
        result.computed_checksum = running_sum_reg;
        result.stored_checksum   = s_item.header_byte;
        result.rom_banks         = decoded.rom_banks;
        result.ram_banks         = decoded.ram_banks;
        result.mapper_class      = decoded.mapper_class;
        result.has_battery       = decoded.has_battery;
        result.cart_type_out     = cart_type_reg;
        result.version_out       = version_byte_reg;
    end

    assign result_load = accept && is_check;

    // Output register with a skid stage behind it.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (result_load) begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (result_load) begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            logo_mismatch_reg <= 1'b0;
            running_sum_reg   <= 8'd0;
            cart_type_reg     <= 8'd0;
            rom_size_code_reg <= 8'd0;
            ram_size_code_reg <= 8'd0;
            version_byte_reg  <= 8'd0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end else begin
            logo_mismatch_reg <= logo_mismatch_next;
            running_sum_reg   <= running_sum_next;
            cart_type_reg     <= cart_type_next;
            rom_size_code_reg <= rom_size_code_next;
            ram_size_code_reg <= ram_size_code_next;
            version_byte_reg  <= version_byte_next;
            out_valid_reg     <= out_valid_next;
            skid_valid_reg    <= skid_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_data_reg;

endmodule
